### rtl/length_delimited_frame_capture_defines.svh
// Assertion macros for the length-delimited frame capture block.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef LENGTH_DELIMITED_FRAME_CAPTURE_DEFINES_SVH
`define LENGTH_DELIMITED_FRAME_CAPTURE_DEFINES_SVH

// same-cycle implication
`define LFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lfc_pkg.sv
// Shared types and constants of the length-delimited frame capture block.
// No dependencies.
package lfc_pkg;

  localparam int unsigned DEFAULT_BUFFER_DEPTH = 1024;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned FLEN_W  = 11;
  localparam int unsigned DECL_W  = 16;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'hBB;

  // byte counts within a frame
  localparam int unsigned LEN_HI_COUNT   = 2;
  localparam int unsigned LEN_LO_COUNT   = 3;
  localparam int unsigned MIN_END_COUNT  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE  = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_READ  = 2'd2
  } lfc_cmd_e;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_READ  = 1'b1
  } lfc_kind_e;

  typedef enum logic {
    REG_START_BYTE = 1'b0,
    REG_END_BYTE   = 1'b1
  } lfc_reg_e;

  typedef struct packed {
    logic              wr_en;
    logic              done;
    logic [FLEN_W-1:0] frame_len;
  } lfc_evt_t;

endpackage

### rtl/lfc_in_if.sv
// Request channel into the frame capture block: command, byte, read index.
// Depends on lfc_pkg.
interface lfc_in_if import lfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] data_byte;
  logic [IDX_W-1:0]  read_index;

  modport source(output valid, cmd, data_byte, read_index, input ready);
  modport sink(input valid, cmd, data_byte, read_index, output ready);
endinterface

### rtl/lfc_out_if.sv
// Result channel out of the frame capture block.
// Depends on lfc_pkg.
interface lfc_out_if import lfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [FLEN_W-1:0] frame_length;
  logic [BYTE_W-1:0] read_byte;

  modport source(output valid, kind, frame_length, read_byte, input ready);
  modport sink(input valid, kind, frame_length, read_byte, output ready);
endinterface

### rtl/lfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lfc_apb_regs.sv
// APB register file: start byte and end byte.
// Depends on lfc_pkg.
module lfc_apb_regs import lfc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [BYTE_W-1:0] start_byte_o,
  output logic [BYTE_W-1:0] end_byte_o
);

  logic [BYTE_W-1:0] start_q, start_d;
  logic [BYTE_W-1:0] end_q, end_d;
  lfc_reg_e          sel;
  logic              wr;

  assign pready = 1'b1;
  assign sel    = lfc_reg_e'(paddr[2]);
  assign wr     = psel && penable && pwrite;

  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    if (wr) begin
      case (sel)
        REG_START_BYTE: start_d = pwdata[BYTE_W-1:0];
        REG_END_BYTE:   end_d   = pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_START_BYTE: prdata = APB_DW'(start_q);
      REG_END_BYTE:   prdata = APB_DW'(end_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_BYTE_RST;
      end_q   <= END_BYTE_RST;
    end else begin
      start_q <= start_d;
      end_q   <= end_d;
    end
  end

  assign start_byte_o = start_q;
  assign end_byte_o   = end_q;

endmodule

### rtl/lfc_parser.sv
// Frame parser: write position, declared length, completion decision.
// Depends on lfc_pkg and the assertion macro header.
`include "length_delimited_frame_capture_defines.svh"

module lfc_parser import lfc_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            acc_i,
  input  logic [CMD_W-1:0]                cmd_i,
  input  logic [BYTE_W-1:0]               data_i,
  input  logic [BYTE_W-1:0]               start_byte_i,
  input  logic [BYTE_W-1:0]               end_byte_i,
  output lfc_evt_t                        evt_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr_o
);

  localparam int unsigned PW = $clog2(BUFFER_DEPTH + 1);

  logic [PW-1:0]     wp_q, wp_d;
  logic [DECL_W-1:0] decl_q, decl_d;
  logic [BYTE_W-1:0] hi_q, hi_d;
  logic [DECL_W-1:0] decl_eff;
  logic [31:0]       count;

  assign count     = 32'(wp_q) + 32'd1;
  assign wr_addr_o = wp_q[$clog2(BUFFER_DEPTH)-1:0];
  assign decl_eff  = (count == 32'(LEN_LO_COUNT) && decl_q == '0) ? {hi_q, data_i} : decl_q;

  always_comb begin
    wp_d            = wp_q;
    decl_d          = decl_q;
    hi_d            = hi_q;
    evt_o.wr_en     = 1'b0;
    evt_o.done      = 1'b0;
    evt_o.frame_len = count[FLEN_W-1:0];
    if (acc_i && cmd_i == CMD_FLUSH) begin
      wp_d   = '0;
      decl_d = '0;
    end else if (acc_i && cmd_i == CMD_BYTE) begin
      if (wp_q == '0) begin
        if (data_i == start_byte_i) begin
          evt_o.wr_en = 1'b1;
          wp_d        = PW'(1);
          decl_d      = '0;
        end
      end else if (32'(wp_q) >= 32'(BUFFER_DEPTH)) begin
        wp_d   = '0;
        decl_d = '0;
      end else begin
        evt_o.wr_en = 1'b1;
        wp_d        = count[PW-1:0];
        decl_d      = decl_eff;
        if (count == 32'(LEN_HI_COUNT)) begin
          hi_d = data_i;
        end
        if (data_i == end_byte_i && count > 32'(MIN_END_COUNT)) begin
          evt_o.done = 1'b1;
          wp_d       = '0;
          decl_d     = '0;
        end else if (decl_eff != '0 && count >= 32'(decl_eff) + 32'd1) begin
          evt_o.done = (data_i == end_byte_i);
          wp_d       = '0;
          decl_d     = '0;
        end else if (count >= 32'(BUFFER_DEPTH)) begin
          wp_d   = '0;
          decl_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      decl_q <= '0;
    end else begin
      wp_q   <= wp_d;
      decl_q <= decl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
  end

  `LFC_ASSERT_IMP(a_done_on_byte, evt_o.done, acc_i && cmd_i == CMD_BYTE, "completion without a byte")
  `LFC_ASSERT_IMP(a_wp_bound, 1'b1, 32'(wp_q) < 32'(BUFFER_DEPTH), "write position at buffer end")
  `LFC_ASSERT_IMP(a_decl_late, decl_q != '0, 32'(wp_q) >= 32'(LEN_LO_COUNT), "length before byte 3")

endmodule

### rtl/length_delimited_frame_capture.sv
// Top level of the length-delimited frame capture block.
// Depends on lfc_pkg, lfc_in_if, lfc_out_if, lfc_ram, lfc_apb_regs, lfc_parser.
//
// channel   | dir | handshake     | payload
// ----------+-----+---------------+------------------------------------
// in_i      | in  | valid/ready   | cmd, data_byte, read_index
// out_o     | out | valid/ready   | kind, frame_length, read_byte
// apb       | in  | psel/penable  | paddr, pwdata, prdata (pready = 1)
//
// One request per cycle while in_i.ready is high; each result passes through
// the stage register, then the result register, which takes the frame store's registered read data.
// A stage register plus the result register keep input flowing while a
// result waits; input stalls only when both hold results.
// Reset clears parser position, length and handshake state; the frame store is not cleared.
`include "length_delimited_frame_capture_defines.svh"

module length_delimited_frame_capture import lfc_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lfc_in_if.sink            in_i,
  lfc_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic [BYTE_W-1:0] start_byte, end_byte;
  lfc_evt_t          evt;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic [31:0]       idx_ext;
  logic              acc, is_read, in_range, re, s1_adv;

  logic              s1_v_q, s1_v_d;
  lfc_kind_e         s1_kind_q;
  logic [FLEN_W-1:0] s1_len_q;
  logic              s1_rng_q;

  logic              out_v_q, out_v_d;
  lfc_kind_e         out_kind_q;
  logic [FLEN_W-1:0] out_len_q;
  logic [BYTE_W-1:0] out_byte_q;

  lfc_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start_byte_o (start_byte),
    .end_byte_o   (end_byte)
  );

  lfc_parser #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .cmd_i        (in_i.cmd),
    .data_i       (in_i.data_byte),
    .start_byte_i (start_byte),
    .end_byte_i   (end_byte),
    .evt_o        (evt),
    .wr_addr_o    (wr_addr)
  );

  lfc_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (evt.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_i.data_byte),
    .re_i    (re),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign s1_adv     = !out_v_q || out_o.ready;
  assign in_i.ready = !s1_v_q || s1_adv;
  assign acc        = in_i.valid && in_i.ready;
  assign is_read    = (in_i.cmd == CMD_READ);
  assign idx_ext    = 32'(in_i.read_index);
  assign in_range   = idx_ext < 32'(BUFFER_DEPTH);
  assign rd_addr    = idx_ext[AW-1:0];
  assign re         = acc && is_read && in_range;

  always_comb begin
    s1_v_d = s1_v_q;
    if (acc) begin
      s1_v_d = is_read || evt.done;
    end else if (s1_adv) begin
      s1_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (s1_adv) begin
      out_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_kind_q <= is_read ? KIND_READ : KIND_FRAME;
      s1_len_q  <= is_read ? '0 : evt.frame_len;
      s1_rng_q  <= in_range;
    end
    if (s1_adv) begin
      out_kind_q <= s1_kind_q;
      out_len_q  <= s1_len_q;
      out_byte_q <= (s1_kind_q == KIND_READ && s1_rng_q) ? rd_data : '0;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.frame_length = out_len_q;
  assign out_o.read_byte    = out_byte_q;

  `LFC_ASSERT_NXT(a_read_staged, re, s1_v_q && s1_kind_q == KIND_READ, "read lost in stage")
  `LFC_ASSERT_NXT(a_no_phantom, acc && !is_read && !evt.done, !s1_v_q, "result without cause")
  `LFC_ASSERT_NXT(a_out_drain, out_v_q && out_o.ready && !s1_v_q, !out_v_q, "result repeated")

endmodule
